// ===== hw/rtl/qdl_pkg.sv =====
// Shared types and codes for the Q16.16 dense layer with ReLU.
`timescale 1ns / 1ps
`default_nettype none
package qdl_pkg;

  // Input operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_NEURON_COUNT = 2'd1;
  localparam logic [1:0] CFG_RELU_ENABLE  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [5:0]         act_index;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         neuron_index;
    logic signed [31:0] neuron_value;
    logic               last_neuron;
  } out_req_t;

  typedef struct packed {
    logic [6:0] input_count;
    logic [7:0] neuron_count;
    logic       relu_enable;
  } cfg_t;

  // One classified word handed from the front end to the accumulator.
  typedef struct packed {
    logic               is_bias;
    logic               is_end;
    logic               relu;
    logic               last;
    logic [7:0]         neuron_index;
    logic signed [31:0] value;
    logic signed [31:0] act;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qdl_fifo.sv =====
// Small synchronous FIFO used between the pipeline parts.
`timescale 1ns / 1ps
`default_nettype none
module qdl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qdl_front.sv =====
// Front end: activation store, weight sequencing and neuron bookkeeping.
`timescale 1ns / 1ps
`default_nettype none
module qdl_front
  import qdl_pkg::*;
#(
  parameter int MAX_INPUTS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    in_push,
  input  wire in_req_t in_data,
  output      logic    in_full,
  output      logic    cmd_push,
  output      cmd_t    cmd_data,
  input  wire logic    cmd_full
);

  localparam int         AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic [7:0] MAX_W = 8'(MAX_INPUTS);

  logic [31:0] act_mem [MAX_INPUTS];
  logic [31:0] act_rd_r;

  logic       s1_valid_r, s1_valid_nxt;
  cmd_t       s1_cmd_r, s1_cmd_nxt;
  logic       s1_slot_ok_r, slot_ok;
  logic [6:0] pos_r, pos_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic       accept, is_load, is_weight, load_ok;
  logic [7:0] n_in, n_out, slot, load_slot;
  logic       word_end, layer_last;

  assign in_full   = s1_valid_r && cmd_full;
  assign accept    = in_push && !in_full;
  assign is_load   = accept && (in_data.op == OP_LOAD);
  assign is_weight = accept && (in_data.op == OP_WEIGHT);
  assign load_slot = {2'b00, in_data.act_index};
  assign load_ok   = (load_slot < MAX_W);

  // Effective counts: zero counts as one, input count limited to the store.
  always_comb begin
    if (cfg.input_count == '0) begin
      n_in = 8'd1;
    end else if ({1'b0, cfg.input_count} > MAX_W) begin
      n_in = MAX_W;
    end else begin
      n_in = {1'b0, cfg.input_count};
    end
    n_out = (cfg.neuron_count == '0) ? 8'd1 : cfg.neuron_count;
  end

  assign slot       = {1'b0, pos_r} - 8'd1;
  assign slot_ok    = (slot < MAX_W);
  assign word_end   = (pos_r != '0) && !({1'b0, pos_r} < n_in);
  assign layer_last = (cnt_r >= (n_out - 8'd1));

  always_comb begin
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    s1_valid_nxt = s1_valid_r && cmd_full;
    s1_cmd_nxt   = s1_cmd_r;
    if (is_weight) begin
      s1_valid_nxt            = 1'b1;
      s1_cmd_nxt.is_bias      = (pos_r == '0);
      s1_cmd_nxt.is_end       = word_end;
      s1_cmd_nxt.relu         = cfg.relu_enable;
      s1_cmd_nxt.last         = layer_last;
      s1_cmd_nxt.neuron_index = cnt_r;
      s1_cmd_nxt.value        = in_data.value;
      s1_cmd_nxt.act          = '0;
      if (pos_r == '0) begin
        pos_nxt = 7'd1;
      end else if (word_end) begin
        pos_nxt = '0;
        cnt_nxt = layer_last ? '0 : cnt_r + 8'd1;
      end else begin
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pos_r      <= pos_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
    if (is_weight) begin
      s1_slot_ok_r <= slot_ok;
      act_rd_r     <= act_mem[slot[AW-1:0]];
    end
    if (is_load && load_ok) begin
      act_mem[load_slot[AW-1:0]] <= in_data.value;
    end
  end

  always_comb begin
    cmd_push     = s1_valid_r && !cmd_full;
    cmd_data     = s1_cmd_r;
    cmd_data.act = s1_slot_ok_r ? act_rd_r : '0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qdl_back.sv =====
// Back end: Q16.16 multiply, rounding, saturating accumulate and ReLU.
`timescale 1ns / 1ps
`default_nettype none
module qdl_back
  import qdl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_empty,
  input  wire cmd_t     cmd_data,
  output      logic     cmd_pop,
  output      logic     res_push,
  output      out_req_t res_data,
  input  wire logic     res_full
);

  localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_MIN = -48'sh0000_8000_0000;

  logic               p_valid_r, p_valid_nxt;
  logic               p_bias_r, p_end_r, p_relu_r, p_last_r;
  logic [7:0]         p_index_r;
  logic signed [31:0] p_value_r;
  logic signed [63:0] p_prod_r;
  logic signed [31:0] acc_r, acc_nxt;

  logic               adv;
  logic signed [63:0] rounded;
  logic signed [47:0] q_wide;
  logic signed [31:0] q_sat;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;

  assign adv         = !(p_valid_r && p_end_r && res_full);
  assign cmd_pop     = adv && !cmd_empty;
  assign p_valid_nxt = adv ? !cmd_empty : p_valid_r;

  // Round to nearest with ties away from zero in a single add.
  always_comb begin
    rounded = p_prod_r + (p_prod_r[63] ? 64'sd32767 : 64'sd32768);
    q_wide  = rounded[63:16];
    if (q_wide > SAT_MAX) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (q_wide < SAT_MIN) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = q_wide[31:0];
    end
    sum_wide = {acc_r[31], acc_r} + {q_sat[31], q_sat};
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (p_valid_r && adv) begin
      acc_nxt = p_bias_r ? p_value_r : sum_sat;
    end
    res_push              = p_valid_r && adv && p_end_r && !p_bias_r;
    res_data.neuron_index = p_index_r;
    res_data.neuron_value = (p_relu_r && sum_sat[31]) ? '0 : sum_sat;
    res_data.last_neuron  = p_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      p_valid_r <= p_valid_nxt;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      p_bias_r  <= cmd_data.is_bias;
      p_end_r   <= cmd_data.is_end;
      p_relu_r  <= cmd_data.relu;
      p_last_r  <= cmd_data.last;
      p_index_r <= cmd_data.neuron_index;
      p_value_r <= cmd_data.value;
      p_prod_r  <= cmd_data.act * cmd_data.value;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/q16_dense_layer_relu_core.sv =====
// Top level of the Q16.16 fully connected layer with optional ReLU.
`timescale 1ns / 1ps
`default_nettype none
// Usage: configure input_count, neuron_count and relu_enable through the
// cfg_we / cfg_index / cfg_wdata write port while the block is idle. Then
// push load requests (op 0) to fill the activation store, and weight requests
// (op 1): per neuron one bias word followed by input_count weight words.
// The input channel is a queue: a request is taken when in_push is high and
// in_full is low. The result channel is a queue too: while out_empty is low
// the oldest result is on out_data, and out_pop takes it.
// Throughput is one request per cycle while in_full stays low; the single
// multiply-accumulate with the accumulator fed back around one register sets
// that figure. The activation is read at the edge that takes a neuron's last
// weight; the word then passes the command queue, the product register and
// the result queue before its result is on out_data.
// When the receiver stops popping, the result queue fills, the accumulator
// stage holds, the command queue fills, and only then in_full rises; until
// then requests keep flowing in.
// Reset (rst_n low at a clock edge) empties both queues, clears the
// accumulator and the weight and neuron counters, and sets the registers to
// input_count 1, neuron_count 1 and ReLU on. The activation store is not
// cleared; slots must be loaded before a weight reads them.
module q16_dense_layer_relu_core
  import qdl_pkg::*;
#(
  parameter int MAX_INPUTS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire in_req_t    in_data,
  output      logic       in_full,
  output      logic       out_empty,
  input  wire logic       out_pop,
  output      out_req_t   out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  localparam int QDEPTH = 4;

  cfg_t     cfg_r, cfg_nxt;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t     cmd_wdata, cmd_rdata;
  logic     res_push, res_full;
  out_req_t res_wdata;

  // Configuration registers; an index beyond the list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:  cfg_nxt.input_count  = cfg_wdata[6:0];
        CFG_NEURON_COUNT: cfg_nxt.neuron_count = cfg_wdata;
        CFG_RELU_ENABLE:  cfg_nxt.relu_enable  = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_count  <= 7'd1;
      cfg_r.neuron_count <= 8'd1;
      cfg_r.relu_enable  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies each request and reads the activation it needs.
  qdl_front #(
    .MAX_INPUTS(MAX_INPUTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  // Command queue decoupling the front end from the accumulator.
  qdl_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // The back end multiplies, rounds and accumulates, and emits neuron sums.
  qdl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .res_full  (res_full)
  );

  // Result queue; its head drives the output ports.
  qdl_fifo #(
    .WIDTH($bits(out_req_t)),
    .DEPTH(QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

`ifndef SYNTHESIS
  // The accumulator stage must hold a finished sum rather than lose it.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // The front end must not hand a word to a full command queue.
  a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full command queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/neuron_sum_checker.sv =====
// Checker for the Q16.16 dense layer: predicts each neuron sum and compares results.
`timescale 1ns / 1ps
module neuron_sum_checker
  import qdl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  in_req_t    in_data,
  input  logic       out_empty,
  input  logic       out_pop,
  input  out_req_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding
);

  localparam int     SLOTS      = 64;
  localparam longint SUM_HI     = 64'sd2147483647;
  localparam longint SUM_LO     = -64'sd2147483648;

  logic signed [31:0] act_store [SLOTS];
  logic signed [31:0] running_sum;
  logic [6:0]         word_pos;
  logic [7:0]         neuron_num;
  logic [6:0]         inputs_reg;
  logic [7:0]         neurons_reg;
  logic               relu_reg;
  out_req_t           neuron_results [$];
  int                 fault_count;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fault_count = 0;
  end

  // Q16.16 product, rounded to nearest with ties away from zero, then saturated.
  function automatic longint q16_product(logic signed [31:0] a, logic signed [31:0] b);
    longint     prod;
    logic [63:0] mag;
    logic [63:0] rnd;
    prod = longint'(a) * longint'(b);
    mag  = (prod < 0) ? -prod : prod;
    rnd  = (mag + 64'h8000) >> 16;
    if (prod < 0) begin
      if (rnd > 64'h8000_0000) rnd = 64'h8000_0000;
      return -longint'(rnd);
    end
    if (rnd > 64'h7FFF_FFFF) rnd = 64'h7FFF_FFFF;
    return longint'(rnd);
  endfunction

  task automatic take_word(input in_req_t w);
    logic [6:0]  n_in;
    logic [7:0]  n_out;
    longint      total;
    logic        at_last;
    out_req_t    res;
    n_in  = (inputs_reg == 0) ? 7'd1 : (inputs_reg > SLOTS) ? 7'(SLOTS) : inputs_reg;
    n_out = (neurons_reg == 0) ? 8'd1 : neurons_reg;
    if (w.op == OP_LOAD) begin
      act_store[w.act_index] = w.value;
      return;
    end
    if (word_pos == 0) begin
      running_sum = w.value;
      word_pos    = 7'd1;
      return;
    end
    total = longint'(running_sum) + q16_product(act_store[word_pos - 7'd1], w.value);
    if (total > SUM_HI) total = SUM_HI;
    if (total < SUM_LO) total = SUM_LO;
    running_sum = total[31:0];
    if (word_pos < n_in) begin
      word_pos = word_pos + 7'd1;
      return;
    end
    if (relu_reg && total < 0) total = 0;
    at_last          = (neuron_num >= n_out - 8'd1);
    res.neuron_index = neuron_num;
    res.neuron_value = total[31:0];
    res.last_neuron  = at_last;
    neuron_results.push_back(res);
    word_pos   = 7'd0;
    neuron_num = at_last ? 8'd0 : neuron_num + 8'd1;
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      foreach (act_store[i]) act_store[i] = '0;
      running_sum = '0;
      word_pos    = '0;
      neuron_num  = '0;
      inputs_reg  = 7'd1;
      neurons_reg = 8'd1;
      relu_reg    = 1'b1;
      neuron_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_COUNT:  inputs_reg  = cfg_wdata[6:0];
          CFG_NEURON_COUNT: neurons_reg = cfg_wdata[7:0];
          CFG_RELU_ENABLE:  relu_reg    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (neuron_results.size() == 0) begin
          fault_count++;
          $display("%0t: result with nothing expected: index %0d value %h last %b",
                   $time, out_data.neuron_index, out_data.neuron_value,
                   out_data.last_neuron);
        end else begin
          want = neuron_results.pop_front();
          if (out_data.neuron_index !== want.neuron_index ||
              out_data.neuron_value !== want.neuron_value ||
              out_data.last_neuron !== want.last_neuron) begin
            fault_count++;
            $display("%0t: expected index %0d value %h last %b, %s",
                     $time, want.neuron_index, want.neuron_value, want.last_neuron,
                     $sformatf("got index %0d value %h last %b",
                               out_data.neuron_index, out_data.neuron_value,
                               out_data.last_neuron));
          end
        end
      end
      if (in_push && !in_full) take_word(in_data);
    end
    mismatches  <= fault_count;
    outstanding <= neuron_results.size();
  end

endmodule

// ===== tb/q16_dense_layer_relu_core_tb.sv =====
// Testbench top for the Q16.16 dense layer: drives requests and registers, gives the verdict.
`timescale 1ns / 1ps
module q16_dense_layer_relu_core_tb;
  import qdl_pkg::*;

  // The register file decodes two index bits; the fourth index holds no register.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Drain pause after the last predicted result, for words still in the block.
  localparam int DRAIN_CYCLES = 8;
  // The long receiver hold-off must outlast the block's internal queues by far.
  localparam int HOLD_CYCLES  = 200;
  // Watchdog limit; a correct run ends well before it.
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  in_req_t    in_data;
  logic       in_full;
  logic       out_empty;
  logic       out_pop;
  out_req_t   out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  bit hold_pop      = 1'b0;
  bit squeeze_go    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  q16_dense_layer_relu_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  neuron_sum_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake or a result that never shows up ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver. Pop is redrawn every cycle, so stalls land on every pipeline phase.
  // While the long hold-off runs, pop stays low no matter what the draw says.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      out_pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
    end
  end

  // The long hold-off lives in its own process and counts its own cycles, so the
  // sender keeps offering requests until the block backs up and raises in_full.
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // Mostly modest Q16.16 values so that sums stay meaningful, with a share of
  // both extremes and of full 32-bit patterns so that every bit toggles and the
  // saturation paths get exercised.
  function automatic logic [31:0] pick_value();
    int v;
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: begin
        v = int'($urandom_range(524288)) - 262144;
        return v;
      end
    endcase
  endfunction

  // Offer one request and hold it until it is taken. Push is lowered only for
  // real idle cycles, so back-to-back requests never see a drop in push.
  task automatic send_item(input logic op, input logic [5:0] idx, input logic [31:0] val);
    in_req_t req;
    req.op        = op;
    req.act_index = idx;
    req.value     = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all three registers back to back. Unused upper data bits get random
  // values since the block must mask them off.
  task automatic program_layer(input int ic, input int nc, input bit relu, input bit spare);
    cfg_write(CFG_INPUT_COUNT, {1'($urandom_range(1)), 7'(ic)});
    cfg_write(CFG_NEURON_COUNT, 8'(nc));
    cfg_write(CFG_RELU_ENABLE, {7'($urandom), relu});
    if (spare) cfg_write(CFG_SPARE, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stop offering, let every predicted result come out, then leave room for
  // work on words that produce no result before anything touches the registers.
  // The first edge lets the checker's count catch up with the last request.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE:       begin send_idle_pct = 0;  stall_pct <= 0;  end
      FLOW_SEND_IDLE:  begin send_idle_pct = 83; stall_pct <= 0;  end
      FLOW_RECV_STALL: begin send_idle_pct = 0;  stall_pct <= 83; end
      default:         begin send_idle_pct = 31; stall_pct <= 31; end
    endcase
  endtask

  // One random phase. A phase may stop in the middle of a neuron or a layer, so
  // the next register setting takes over a partly built sum; the block must
  // then end the neuron and the layer by the new counts.
  task automatic run_phase(input int ic, input int nc, input bit relu, input int count,
                           input flow_mode_t mode, input bit squeeze);
    settle();
    program_layer(ic, nc, relu, 1'b0);
    set_flow(mode);
    if (squeeze) squeeze_go = 1'b1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15)
        send_item(OP_LOAD, 6'($urandom_range(63)), pick_value());
      else
        send_item(OP_WEIGHT, 6'($urandom_range(63)), pick_value());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_INPUT_COUNT;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first layer: two inputs, three neurons, raw sums.
    settle();
    program_layer(2, 3, 1'b0, 1'b1);
    send_item(OP_LOAD, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_LOAD, 6'd1, 32'h8000_0000);
    send_item(OP_LOAD, 6'd63, 32'h0001_8000);
    // Largest bias plus a product that saturates high: the sum clamps at the top.
    send_item(OP_WEIGHT, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_WEIGHT, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_WEIGHT, 6'd0, 32'h0000_0001);
    // Most negative bias and products at both saturation limits.
    send_item(OP_WEIGHT, 6'd63, 32'h8000_0000);
    send_item(OP_WEIGHT, 6'd63, 32'h8000_0000);
    send_item(OP_WEIGHT, 6'd63, 32'h8000_0000);
    // Exact half-LSB products: rounding ties go away from zero on both signs.
    send_item(OP_LOAD, 6'd0, 32'h0000_0001);
    send_item(OP_LOAD, 6'd1, 32'hFFFF_FFFF);
    send_item(OP_WEIGHT, 6'd0, 32'h0000_0000);
    send_item(OP_WEIGHT, 6'd0, 32'h0000_8000);
    send_item(OP_WEIGHT, 6'd0, 32'h0000_8000);

    // Second layer: a zero input count acts as one and a zero neuron count acts
    // as one, with ReLU on so negative sums come out as zero.
    settle();
    program_layer(0, 0, 1'b1, 1'b0);
    send_item(OP_WEIGHT, 6'd0, 32'hFFFF_0000);
    send_item(OP_WEIGHT, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_WEIGHT, 6'd0, 32'h8000_0000);
    send_item(OP_WEIGHT, 6'd0, 32'h8000_0000);
    send_item(OP_WEIGHT, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_WEIGHT, 6'd0, 32'h7FFF_FFFF);

    // Fill every activation slot so no weight ever reads an unloaded one.
    for (int s = 0; s < 64; s++) send_item(OP_LOAD, 6'(s), pick_value());

    // Random phases across the register range, each with its own flow pattern.
    run_phase(64, 2, 1'b1, 100, FLOW_FREE, 1'b0);
    run_phase(127, 1, 1'b0, 100, FLOW_SEND_IDLE, 1'b0);
    run_phase(0, 255, 1'b1, 620, FLOW_BOTH, 1'b0);
    run_phase(3, 4, 1'b0, 60, FLOW_RECV_STALL, 1'b0);
    // Short neurons give a result every other word, so the hold-off backs the
    // block up quickly and in_full has to rise.
    run_phase(1, 1, 1'b1, 60, FLOW_FREE, 1'b1);
    run_phase(2, 0, 1'b0, 50, FLOW_SEND_IDLE, 1'b0);
    run_phase(8, 3, 1'b1, 60, FLOW_BOTH, 1'b0);
    run_phase(65, 5, 1'b0, 60, FLOW_RECV_STALL, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
